// File: hw/rtl/cmh_pkg.sv
package cmh_pkg;

   localparam int CompW   = 8;
   localparam int SumW    = 10;            // r+g+b up to 765
   localparam int OnW     = 4;             // 0..9 lit cells
   localparam int NumW    = 13;            // 2*c*on + sum up to 5355
   localparam int Sum2W   = SumW + 1;
   localparam int CntW    = 4;
   localparam int CellW   = 2;
   localparam int Cells   = 9;
   localparam int Colours = 3;
   localparam int FullScale = 255;
   localparam int ScaleW  = 12;            // 10*peak up to 2550

   localparam int ColRed   = 0;
   localparam int ColGreen = 1;
   localparam int ColBlue  = 2;

   typedef enum logic [CellW-1:0] {
      CELL_EMPTY = 2'd0,
      CELL_RED   = 2'd1,
      CELL_GREEN = 2'd2,
      CELL_BLUE  = 2'd3
   } cell_code_type;

   // tenth-bucket of peak/255, capped at the cell count
   function automatic logic [OnW-1:0] on_count(input logic [CompW-1:0] peak);
      logic [ScaleW-1:0] scaled;
      logic [OnW-1:0]    on;
      scaled = ScaleW'(peak) * ScaleW'(10);
      on     = '0;
      for (int k = 1; k <= Cells; k++) begin
         if (scaled >= ScaleW'(FullScale * k)) begin
            on = OnW'(k);
         end
      end
      return on;
   endfunction

endpackage

// File: hw/rtl/cmh_pixel_if.sv
interface cmh_pixel_if;
   import cmh_pkg::*;

   logic             valid;
   logic             ready;
   logic [CompW-1:0] red;
   logic [CompW-1:0] green;
   logic [CompW-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// File: hw/rtl/cmh_mpix_if.sv
interface cmh_mpix_if;
   import cmh_pkg::*;

   logic             valid;
   logic             ready;
   logic [CellW-1:0] cell_0_0;
   logic [CellW-1:0] cell_0_1;
   logic [CellW-1:0] cell_0_2;
   logic [CellW-1:0] cell_1_0;
   logic [CellW-1:0] cell_1_1;
   logic [CellW-1:0] cell_1_2;
   logic [CellW-1:0] cell_2_0;
   logic [CellW-1:0] cell_2_1;
   logic [CellW-1:0] cell_2_2;

   modport source (
      output valid,
      output cell_0_0, output cell_0_1, output cell_0_2,
      output cell_1_0, output cell_1_1, output cell_1_2,
      output cell_2_0, output cell_2_1, output cell_2_2,
      input  ready
   );
   modport sink (
      input  valid,
      input  cell_0_0, input cell_0_1, input cell_0_2,
      input  cell_1_0, input cell_1_1, input cell_1_2,
      input  cell_2_0, input cell_2_1, input cell_2_2,
      output ready
   );

endinterface

// File: hw/rtl/color_megapixel_halftoner.sv
// Five-stage pipeline: each pixel transfer fills stage 1 and passes through stages 2 to
// 4 before its megapixel is presented from the stage 5 register.
// Throughput is one pixel per clock; each stage holds when the one after it
// is full and stalled, and empty stages are filled through.
// The longest stage is the nine parallel compares of the rounded shares.
// Synchronous reset empties every stage; no result is pending afterwards.
module color_megapixel_halftoner (
   input  logic       clock,
   input  logic       reset,
   cmh_pixel_if.sink  req_chan,
   cmh_mpix_if.source rsp_chan
);
   import cmh_pkg::*;

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   // stage 1: components, peak, sum
   logic [CompW-1:0] comp_s1_ff [Colours];
   logic [CompW-1:0] peak_s1_ff;
   logic [SumW-1:0]  sum_s1_ff;
   logic [CompW-1:0] peak_in;
   logic [SumW-1:0]  sum_in;

   // stage 2: on-count
   logic [CompW-1:0] comp_s2_ff [Colours];
   logic [SumW-1:0]  sum_s2_ff;
   logic [OnW-1:0]   on_s2_ff;

   // stage 3: numerators and doubled sum
   logic [NumW-1:0]  num_s3_ff [Colours];
   logic [NumW-1:0]  num_in    [Colours];
   logic [Sum2W-1:0] sum2_s3_ff;
   logic [OnW-1:0]   on_s3_ff;

   // stage 4: per-colour counts
   logic [CntW-1:0]  cnt_s4_ff [Colours];
   logic [CntW-1:0]  cnt_in    [Colours];
   logic [OnW-1:0]   on_s4_ff;

   // stage 5: output cells
   cell_code_type    cells_ff [Cells];
   cell_code_type    cells_in [Cells];

   assign en5 = !v5_ff || rsp_chan.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // peak and sum of the incoming pixel
   always_comb begin
      peak_in = req_chan.red;
      if (req_chan.green > peak_in) peak_in = req_chan.green;
      if (req_chan.blue > peak_in) peak_in = req_chan.blue;
      sum_in = SumW'(req_chan.red) + SumW'(req_chan.green) + SumW'(req_chan.blue);
   end

   // numerator 2*c*on + sum of the round-half-up share
   always_comb begin
      for (int c = 0; c < Colours; c++) begin
         num_in[c] = {(NumW - 1)'((NumW - 1)'(comp_s2_ff[c]) * (NumW - 1)'(on_s2_ff)), 1'b0}
                     + NumW'(sum_s2_ff);
      end
   end

   // share = floor(num / 2sum) <= 9: count the multiples of 2sum not above num
   // (nine times the doubled sum needs one bit more than the numerator)
   always_comb begin
      for (int c = 0; c < Colours; c++) begin
         cnt_in[c] = '0;
         for (int n = 1; n <= Cells; n++) begin
            if ((sum2_s3_ff != '0) &&
                ((NumW + 1)'(sum2_s3_ff) * (NumW + 1)'(n) <= (NumW + 1)'(num_s3_ff[c])))
            begin
               cnt_in[c] = cnt_in[c] + CntW'(1);
            end
         end
      end
   end

   // row-major fill: reds, greens, blues, then empty
   always_comb begin
      logic [CntW:0]   upto_g;
      logic [CntW+1:0] upto_b;
      upto_g = (CntW + 1)'(cnt_s4_ff[ColRed]) + (CntW + 1)'(cnt_s4_ff[ColGreen]);
      upto_b = (CntW + 2)'(upto_g) + (CntW + 2)'(cnt_s4_ff[ColBlue]);
      for (int k = 0; k < Cells; k++) begin
         if ((CntW + 2)'(k) < (CntW + 2)'(cnt_s4_ff[ColRed])) begin
            cells_in[k] = CELL_RED;
         end else if ((CntW + 2)'(k) < (CntW + 2)'(upto_g)) begin
            cells_in[k] = CELL_GREEN;
         end else if ((CntW + 2)'(k) < upto_b) begin
            cells_in[k] = CELL_BLUE;
         end else begin
            cells_in[k] = CELL_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_chan.valid) begin
         comp_s1_ff[ColRed]   <= req_chan.red;
         comp_s1_ff[ColGreen] <= req_chan.green;
         comp_s1_ff[ColBlue]  <= req_chan.blue;
         peak_s1_ff <= peak_in;
         sum_s1_ff  <= sum_in;
      end
      if (en2 && v1_ff) begin
         comp_s2_ff <= comp_s1_ff;
         sum_s2_ff  <= sum_s1_ff;
         on_s2_ff   <= on_count(peak_s1_ff);
      end
      if (en3 && v2_ff) begin
         num_s3_ff  <= num_in;
         sum2_s3_ff <= {sum_s2_ff, 1'b0};
         on_s3_ff   <= on_s2_ff;
      end
      if (en4 && v3_ff) begin
         cnt_s4_ff <= cnt_in;
         on_s4_ff  <= on_s3_ff;
      end
      if (en5 && v4_ff) begin
         cells_ff <= cells_in;
      end
   end

   assign rsp_chan.valid    = v5_ff;
   assign rsp_chan.cell_0_0 = cells_ff[0];
   assign rsp_chan.cell_0_1 = cells_ff[1];
   assign rsp_chan.cell_0_2 = cells_ff[2];
   assign rsp_chan.cell_1_0 = cells_ff[3];
   assign rsp_chan.cell_1_1 = cells_ff[4];
   assign rsp_chan.cell_1_2 = cells_ff[5];
   assign rsp_chan.cell_2_0 = cells_ff[6];
   assign rsp_chan.cell_2_1 = cells_ff[7];
   assign rsp_chan.cell_2_2 = cells_ff[8];

   // a colour never gets more dots than are lit
   a_share_bound: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (cnt_s4_ff[ColRed] <= on_s4_ff) && (cnt_s4_ff[ColGreen] <= on_s4_ff)
                && (cnt_s4_ff[ColBlue] <= on_s4_ff))
      else $error("colour share exceeds on-count");

   // fill is contiguous from the top-left cell
   a_fill_contiguous: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && cells_ff[0] == CELL_EMPTY) |->
         (cells_ff[1] == CELL_EMPTY) && (cells_ff[4] == CELL_EMPTY)
         && (cells_ff[8] == CELL_EMPTY))
      else $error("cells filled after an empty top-left cell");

   // a dark pixel lights nothing
   a_dark_empty: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && on_s4_ff == '0) |->
         (cnt_s4_ff[ColRed] == '0) && (cnt_s4_ff[ColGreen] == '0)
         && (cnt_s4_ff[ColBlue] == '0))
      else $error("dots counted with zero on-count");

   // a stalled result is not overwritten
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !rsp_chan.ready) |=> v5_ff && $stable(cells_ff[0]) && $stable(cells_ff[8]))
      else $error("stalled result lost");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !v5_ff && !v1_ff)
      else $error("pipeline not empty after reset");

endmodule
